// ===== hw/rtl/sffe_pkg.sv =====
// Shared types and constants for the single-frequency filter envelope block.
package sffe_pkg;

	// Default widths of the sample and of the resonator state
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int STATE_BITS_DEF  = 32;

	// Fixed widths of the coefficient, output and configuration port
	localparam int COEF_W     = 16;
	localparam int Q_FRAC     = 15;
	localparam int ENV_W      = 48;
	localparam int SQ_OP_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POLE_COS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLE_SIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIFF     = 2'd2;

	// Multiply step codes of the recursion
	localparam logic [1:0] STEP_COS_RE = 2'd0;
	localparam logic [1:0] STEP_SIN_IM = 2'd1;
	localparam logic [1:0] STEP_COS_IM = 2'd2;
	localparam logic [1:0] STEP_SIN_RE = 2'd3;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       accept;   // take a new sample
		logic       clear;    // start of signal: clear filter state
		logic       mul;      // one coefficient product this cycle
		logic [1:0] step;     // which product
		logic       update;   // round, add drive, saturate, write state
		logic       sq_imag;  // square the imaginary part (else real)
		logic       sq_first; // hold the first square
		logic       load_out; // load the output register
		logic       zero_out; // result is zero (start of signal)
	} cmd_t;

endpackage

// ===== hw/rtl/sffe_ctrl.sv =====
// Controller state machine: sequences accept, recursion, squaring and output.
module sffe_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             start_of_signal,
	output logic             out_valid,
	input  logic             out_ready,
	output sffe_pkg::cmd_t   cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_UPD  = 3'd2;
	localparam logic [2:0] S_SQR  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [1:0] step_q;
	logic       start_q;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Command decode
	always_comb begin
		cmd          = '0;
		cmd.step     = step_q;
		cmd.zero_out = start_q;
		case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				cmd.clear  = in_valid && start_of_signal;
			end
			S_MUL:   cmd.mul = 1'b1;
			S_UPD:   cmd.update = 1'b1;
			S_SQR:   cmd.sq_first = 1'b1;
			S_OUT: begin
				cmd.sq_imag  = 1'b1;
				cmd.load_out = slot_free;
			end
			default: cmd = '0;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			start_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						start_q <= start_of_signal;
						step_q  <= sffe_pkg::STEP_COS_RE;
						state_q <= start_of_signal ? S_OUT : S_MUL;
					end
				end
				S_MUL: begin
					step_q <= step_q + 2'd1;
					if (step_q == sffe_pkg::STEP_SIN_RE) begin
						state_q <= S_UPD;
					end
				end
				S_UPD:   state_q <= S_SQR;
				S_SQR:   state_q <= S_OUT;
				S_OUT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output valid flag: set on load, cleared when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Never overwrite a result that is still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

	// A start beat skips the recursion
	a_start_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && start_of_signal) |=> (state_q == S_OUT))
		else $error("start beat entered recursion");

	// The product sequence always begins at the first step
	a_mul_first: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !start_of_signal) |=>
			(state_q == S_MUL && step_q == sffe_pkg::STEP_COS_RE))
		else $error("recursion started mid-sequence");

endmodule

// ===== hw/rtl/sffe_dp.sv =====
// Datapath: difference, shared coefficient multiplier, state update, envelope.
module sffe_dp #(
	parameter int SAMPLE_BITS = sffe_pkg::SAMPLE_BITS_DEF,
	parameter int STATE_BITS  = sffe_pkg::STATE_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  sffe_pkg::cmd_t                          cmd,
	input  logic signed [SAMPLE_BITS-1:0]           audio_sample,
	input  logic signed [sffe_pkg::COEF_W-1:0]      pole_cos,
	input  logic signed [sffe_pkg::COEF_W-1:0]      pole_sin,
	input  logic                                    diff_en,
	output logic [sffe_pkg::ENV_W-1:0]              envelope_power
);

	localparam int DRV_W  = SAMPLE_BITS + 1;
	localparam int PROD_W = sffe_pkg::COEF_W + STATE_BITS;
	localparam int ACC_W  = PROD_W + 1;
	localparam int RND_W  = ACC_W - sffe_pkg::Q_FRAC;
	localparam int NR_W   = RND_W + 1;
	localparam int MAG_W  = (STATE_BITS > sffe_pkg::SQ_OP_W) ? STATE_BITS
		: sffe_pkg::SQ_OP_W + 1;
	localparam int SQ_W   = 2 * sffe_pkg::SQ_OP_W;

	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic signed [STATE_BITS-1:0]  real_q;
	logic signed [STATE_BITS-1:0]  imag_q;
	logic signed [DRV_W-1:0]       drive_q;
	logic signed [ACC_W-1:0]       acc_r_q;
	logic signed [ACC_W-1:0]       acc_i_q;
	logic [SQ_W-1:0]               sq_q;
	logic                          ovf_q;
	logic [sffe_pkg::ENV_W-1:0]    env_q;

	logic signed [DRV_W-1:0]       x_ext;
	logic signed [DRV_W-1:0]       drive;
	logic signed [sffe_pkg::COEF_W-1:0] coef_op;
	logic signed [STATE_BITS-1:0]  st_op;
	logic signed [PROD_W-1:0]      prod;
	logic signed [ACC_W-1:0]       prod_ext;

	// Drive value: first difference or raw sample
	assign x_ext = {audio_sample[SAMPLE_BITS-1], audio_sample};
	assign drive = diff_en ? (x_ext - {prev_q[SAMPLE_BITS-1], prev_q}) : x_ext;

	// Shared coefficient multiplier: odd steps use sin, middle steps use imag
	assign coef_op  = cmd.step[0] ? pole_sin : pole_cos;
	assign st_op    = (cmd.step[0] ^ cmd.step[1]) ? imag_q : real_q;
	assign prod     = coef_op * st_op;
	assign prod_ext = {prod[PROD_W-1], prod};

	// Round half up, add drive, saturate
	logic signed [ACC_W-1:0]  acc_r_rnd;
	logic signed [ACC_W-1:0]  acc_i_rnd;
	logic signed [NR_W-1:0]   nr;
	logic signed [NR_W-1:0]   ni;
	logic signed [STATE_BITS-1:0] nr_sat;
	logic signed [STATE_BITS-1:0] ni_sat;
	logic signed [STATE_BITS-1:0] st_max;
	logic signed [STATE_BITS-1:0] st_min;

	assign acc_r_rnd = acc_r_q + (ACC_W'(1) <<< (sffe_pkg::Q_FRAC - 1));
	assign acc_i_rnd = acc_i_q + (ACC_W'(1) <<< (sffe_pkg::Q_FRAC - 1));
	assign nr = {acc_r_rnd[ACC_W-1], acc_r_rnd[ACC_W-1:sffe_pkg::Q_FRAC]}
		+ {{(NR_W-DRV_W){drive_q[DRV_W-1]}}, drive_q};
	assign ni = {acc_i_rnd[ACC_W-1], acc_i_rnd[ACC_W-1:sffe_pkg::Q_FRAC]};
	assign st_max = {1'b0, {(STATE_BITS-1){1'b1}}};
	assign st_min = {1'b1, {(STATE_BITS-1){1'b0}}};

	always_comb begin
		if ((&nr[NR_W-1:STATE_BITS-1]) || !(|nr[NR_W-1:STATE_BITS-1])) begin
			nr_sat = nr[STATE_BITS-1:0];
		end else begin
			nr_sat = nr[NR_W-1] ? st_min : st_max;
		end
		if ((&ni[NR_W-1:STATE_BITS-1]) || !(|ni[NR_W-1:STATE_BITS-1])) begin
			ni_sat = ni[STATE_BITS-1:0];
		end else begin
			ni_sat = ni[NR_W-1] ? st_min : st_max;
		end
	end

	// Magnitude and square of one state part
	logic signed [STATE_BITS-1:0] sq_src;
	logic [STATE_BITS-1:0]        mag;
	logic [MAG_W-1:0]             mag_ext;
	logic                         mag_ovf;
	logic [SQ_W-1:0]              sq;
	logic [SQ_W:0]                sq_sum;
	logic [sffe_pkg::ENV_W-1:0]   env;

	assign sq_src  = cmd.sq_imag ? imag_q : real_q;
	assign mag     = sq_src[STATE_BITS-1] ? (-sq_src) : sq_src;
	assign mag_ext = MAG_W'(mag);
	assign mag_ovf = |mag_ext[MAG_W-1:sffe_pkg::SQ_OP_W];
	assign sq      = mag_ext[sffe_pkg::SQ_OP_W-1:0] * mag_ext[sffe_pkg::SQ_OP_W-1:0];
	assign sq_sum  = {1'b0, sq_q} + {1'b0, sq};

	always_comb begin
		if (cmd.zero_out) begin
			env = '0;
		end else if (ovf_q || mag_ovf || sq_sum[SQ_W]) begin
			env = '1;
		end else begin
			env = sq_sum[SQ_W-1:16];
		end
	end

	// Filter state and previous sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			real_q <= '0;
			imag_q <= '0;
		end else begin
			if (cmd.accept) begin
				prev_q <= audio_sample;
			end
			if (cmd.clear) begin
				real_q <= '0;
				imag_q <= '0;
			end else if (cmd.update) begin
				real_q <= nr_sat;
				imag_q <= ni_sat;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			drive_q <= drive;
		end
		if (cmd.mul) begin
			case (cmd.step)
				sffe_pkg::STEP_COS_RE: acc_r_q <= prod_ext;
				sffe_pkg::STEP_SIN_IM: acc_r_q <= acc_r_q - prod_ext;
				sffe_pkg::STEP_COS_IM: acc_i_q <= prod_ext;
				sffe_pkg::STEP_SIN_RE: acc_i_q <= acc_i_q + prod_ext;
				default:               acc_i_q <= acc_i_q;
			endcase
		end
		if (cmd.sq_first) begin
			sq_q  <= sq;
			ovf_q <= mag_ovf;
		end
		if (cmd.load_out) begin
			env_q <= env;
		end
	end

	assign envelope_power = env_q;

	// A start beat leaves the resonator cleared
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (real_q == '0 && imag_q == '0))
		else $error("state not cleared on start");

endmodule

// ===== hw/rtl/single_frequency_filter_envelope.sv =====
// Top level: configuration registers, controller and datapath.
// A normal sample passes through accept, four products on the shared 16xSTATE_BITS
// multiplier, state update and two squares on the 32x32 multiplier before its result
// is loaded; a start-of-signal sample skips the recursion and loads a zero result.
// No new sample is taken until the previous result is loaded, which waits for a free output register.
// Reset clears filter state, previous sample, coefficients; differencing is on.
module single_frequency_filter_envelope #(
	parameter int SAMPLE_BITS = sffe_pkg::SAMPLE_BITS_DEF,
	parameter int STATE_BITS  = sffe_pkg::STATE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_BITS-1:0]        audio_sample,
	input  logic                                 start_of_signal,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [sffe_pkg::ENV_W-1:0]           envelope_power,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [sffe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sffe_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic signed [sffe_pkg::COEF_W-1:0] pole_cos_q;
	logic signed [sffe_pkg::COEF_W-1:0] pole_sin_q;
	logic                               diff_q;
	sffe_pkg::cmd_t                     cmd;

	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_cos_q <= '0;
			pole_sin_q <= '0;
			diff_q     <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				sffe_pkg::REG_POLE_COS: pole_cos_q <= cfg_data;
				sffe_pkg::REG_POLE_SIN: pole_sin_q <= cfg_data;
				sffe_pkg::REG_DIFF:     diff_q     <= cfg_data[0];
				default:                diff_q     <= diff_q;
			endcase
		end
	end

	sffe_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.start_of_signal (start_of_signal),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.cmd             (cmd)
	);

	sffe_dp #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.STATE_BITS  (STATE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.audio_sample   (audio_sample),
		.pole_cos       (pole_cos_q),
		.pole_sin       (pole_sin_q),
		.diff_en        (diff_q),
		.envelope_power (envelope_power)
	);

endmodule

// ===== bench/single_frequency_filter_envelope_test.sv =====
// Self-checking testbench for the single-frequency filter envelope block.
module single_frequency_filter_envelope_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SMP_W        = 16;
	localparam int ST_W         = 32;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 65;
	localparam int HOLD_AT_BEAT = 200;
	localparam int HOLD_CYCLES  = 200;
	// index past the register list
	localparam logic [sffe_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;
	localparam logic [sffe_pkg::ENV_W-1:0]     ENV_MAX  = '1;

	typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

	// One directed step: a sample beat or a register write
	typedef struct packed {
		row_kind_t                       kind;
		logic [sffe_pkg::CFG_IDX_W-1:0]  idx;
		logic [sffe_pkg::CFG_DATA_W-1:0] data;
		logic [SMP_W-1:0]                sample;
		logic                            sos;
		logic                            known;   // power below is typed in, not predicted
		logic [sffe_pkg::ENV_W-1:0]      power;
	} drill_row_t;

	localparam drill_row_t DRILL [30] = '{
		// fresh from reset: zero poles, differencing on
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'h8000, 1'b0, 1'b1, 48'd16384},
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'h7FFF, 1'b0, 1'b1, 48'd65534},
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'h0000, 1'b1, 1'b1, 48'd0},
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'h0001, 1'b0, 1'b1, 48'd0},
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 48'd0},
		// raw samples; upper data bits of the mode register must be dropped
		'{ROW_REG, sffe_pkg::REG_DIFF, 16'hFFFE, 16'h0000, 1'b0, 1'b0, 48'd0},
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'h7FFF, 1'b0, 1'b0, 48'd0},
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'h8000, 1'b0, 1'b0, 48'd0},
		'{ROW_REG,    REG_NONE, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 48'd0},
		// most negative poles: the state grows toward saturation
		'{ROW_REG, sffe_pkg::REG_POLE_COS, 16'h8000, 16'h0000, 1'b0, 1'b0, 48'd0},
		'{ROW_REG, sffe_pkg::REG_POLE_SIN, 16'h8000, 16'h0000, 1'b0, 1'b0, 48'd0},
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'h1234, 1'b1, 1'b1, 48'd0},
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'h7FFF, 1'b0, 1'b0, 48'd0},
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'h7FFF, 1'b0, 1'b0, 48'd0},
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'h8000, 1'b0, 1'b0, 48'd0},
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'h7FFF, 1'b0, 1'b0, 48'd0},
		// most positive poles with differencing back on
		'{ROW_REG, sffe_pkg::REG_POLE_COS, 16'h7FFF, 16'h0000, 1'b0, 1'b0, 48'd0},
		'{ROW_REG, sffe_pkg::REG_POLE_SIN, 16'h7FFF, 16'h0000, 1'b0, 1'b0, 48'd0},
		'{ROW_REG, sffe_pkg::REG_DIFF, 16'h0001, 16'h0000, 1'b0, 1'b0, 48'd0},
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'h8000, 1'b0, 1'b0, 48'd0},
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'h7FFF, 1'b0, 1'b0, 48'd0},
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'h5555, 1'b1, 1'b1, 48'd0},
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'hAAAA, 1'b0, 1'b0, 48'd0},
		// mixed signs
		'{ROW_REG, sffe_pkg::REG_POLE_SIN, 16'h8000, 16'h0000, 1'b0, 1'b0, 48'd0},
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'h8000, 1'b0, 1'b0, 48'd0},
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'h7FFF, 1'b0, 1'b0, 48'd0},
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'h0000, 1'b0, 1'b0, 48'd0},
		'{ROW_REG, sffe_pkg::REG_POLE_COS, 16'h0000, 16'h0000, 1'b0, 1'b0, 48'd0},
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'h7FFF, 1'b1, 1'b1, 48'd0},
		'{ROW_SAMPLE, REG_NONE, 16'h0000, 16'h0000, 1'b0, 1'b0, 48'd0}
	};

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	logic [SMP_W-1:0]                audio_sample;
	logic                            start_of_signal;
	logic                            out_valid;
	logic                            out_ready;
	logic [sffe_pkg::ENV_W-1:0]      envelope_power;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [sffe_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [sffe_pkg::CFG_DATA_W-1:0] cfg_data;

	// Predictor copy of registers and filter state
	logic signed [sffe_pkg::COEF_W-1:0] cos_k    = '0;
	logic signed [sffe_pkg::COEF_W-1:0] sin_k    = '0;
	logic                               diff_on  = 1'b1;
	logic signed [SMP_W-1:0]            last_smp = '0;
	logic signed [ST_W-1:0]             re_acc   = '0;
	logic signed [ST_W-1:0]             im_acc   = '0;

	logic [sffe_pkg::ENV_W-1:0] expected_powers [$];
	int unsigned      sent   = 0;
	int unsigned      taken  = 0;
	int unsigned      errors = 0;
	bit               in_up  = 1'b0;   // shadow of in_valid
	bit               cfg_up = 1'b0;   // shadow of cfg_valid

	single_frequency_filter_envelope #(
		.SAMPLE_BITS(SMP_W),
		.STATE_BITS (ST_W)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.audio_sample   (audio_sample),
		.start_of_signal(start_of_signal),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.envelope_power (envelope_power),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Reset once; every input known from time zero
	initial begin
		arst_n          <= 1'b0;
		in_valid        <= 1'b0;
		audio_sample    <= '0;
		start_of_signal <= 1'b0;
		out_ready       <= 1'b0;
		cfg_valid       <= 1'b0;
		cfg_index       <= '0;
		cfg_data        <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Append one expected power to the scoreboard
	function automatic void queue_power(input logic [sffe_pkg::ENV_W-1:0] p);
		expected_powers = {expected_powers, p};
	endfunction

	// Round half up in Q15
	function automatic longint round_q15(input longint v);
		return (v + (64'sd1 <<< (sffe_pkg::Q_FRAC - 1))) >>> sffe_pkg::Q_FRAC;
	endfunction

	function automatic logic signed [ST_W-1:0] clamp_state(input longint v);
		longint top;
		top = (64'sd1 <<< (ST_W - 1)) - 1;
		if (v > top)
			return ST_W'(top);
		if (v < -top - 1)
			return ST_W'(-top - 1);
		return ST_W'(v);
	endfunction

	// (a^2 + b^2) >> 16, capped at the output width
	function automatic logic [sffe_pkg::ENV_W-1:0] magnitude_power(
			input logic signed [ST_W-1:0] a, input logic signed [ST_W-1:0] b);
		longint      la, lb;
		logic [63:0] sq_a, sq_b;
		logic [64:0] tot;
		la   = longint'(a);
		lb   = longint'(b);
		sq_a = la * la;
		sq_b = lb * lb;
		tot  = ({1'b0, sq_a} + {1'b0, sq_b}) >> 16;
		if (tot > {17'd0, ENV_MAX})
			return ENV_MAX;
		return tot[sffe_pkg::ENV_W-1:0];
	endfunction

	// Advance the resonator by one sample and return its power
	function automatic logic [sffe_pkg::ENV_W-1:0] power_after(
			input logic signed [SMP_W-1:0] x, input logic sos);
		longint drive, nr, ni;
		if (sos) begin
			last_smp = x;
			re_acc   = '0;
			im_acc   = '0;
			return '0;
		end
		drive    = longint'(x) - (diff_on ? longint'(last_smp) : 64'sd0);
		last_smp = x;
		nr = drive + round_q15(longint'(cos_k) * longint'(re_acc)
			- longint'(sin_k) * longint'(im_acc));
		ni = round_q15(longint'(cos_k) * longint'(im_acc)
			+ longint'(sin_k) * longint'(re_acc));
		re_acc = clamp_state(nr);
		im_acc = clamp_state(ni);
		return magnitude_power(re_acc, im_acc);
	endfunction

	// Per-beat wait; every sixth stretch of 48 beats runs back to back
	function automatic int unsigned pause_for(input int unsigned n);
		if (((n / 48) % 6) == 5)
			return 0;
		return $urandom_range(0, 11);
	endfunction

	function automatic logic [sffe_pkg::COEF_W-1:0] pick_coef();
		logic [sffe_pkg::COEF_W-1:0] m;
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3, 4: begin
				// magnitude small enough that the pole stays inside the unit circle
				m = sffe_pkg::COEF_W'($urandom_range(0, 23170));
				return $urandom_range(0, 1) ? -m : m;
			end
			default: return sffe_pkg::COEF_W'($urandom);
		endcase
	endfunction

	function automatic logic [SMP_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return SMP_W'($urandom);
		endcase
	endfunction

	// Register write, only once every pending result has drained
	task automatic write_reg(input logic [sffe_pkg::CFG_IDX_W-1:0] idx,
			input logic [sffe_pkg::CFG_DATA_W-1:0] data);
		if (in_up) begin
			in_valid <= 1'b0;
			in_up = 1'b0;
		end
		while (expected_powers.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_up = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			sffe_pkg::REG_POLE_COS: cos_k = data;
			sffe_pkg::REG_POLE_SIN: sin_k = data;
			sffe_pkg::REG_DIFF: diff_on = data[0];
			default: ;
		endcase
	endtask

	// Offer one sample beat and log its expected power on acceptance
	task automatic send_sample(input logic [SMP_W-1:0] smp, input logic sos,
			input logic known, input logic [sffe_pkg::ENV_W-1:0] power);
		int unsigned                gap;
		logic [sffe_pkg::ENV_W-1:0] want;
		gap = pause_for(sent);
		if (cfg_up) begin
			cfg_valid <= 1'b0;
			cfg_up = 1'b0;
		end
		if (gap != 0) begin
			if (in_up) begin
				in_valid <= 1'b0;
				in_up = 1'b0;
			end
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		audio_sample    <= smp;
		start_of_signal <= sos;
		in_up = 1'b1;
		do @(posedge clk); while (!in_ready);
		want = power_after(smp, sos);
		queue_power(known ? power : want);
		sent++;
	endtask

	// Stimulus: directed rows, then random phases
	initial begin : stimulus
		int unsigned                     ph, k;
		logic                            sos;
		logic [sffe_pkg::CFG_DATA_W-1:0] mode;
		wait (arst_n === 1'b1);
		@(posedge clk);
		foreach (DRILL[i]) begin
			if (DRILL[i].kind == ROW_REG)
				write_reg(DRILL[i].idx, DRILL[i].data);
			else
				send_sample(DRILL[i].sample, DRILL[i].sos, DRILL[i].known, DRILL[i].power);
		end
		for (ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				// unstable pole, raw input, long signal: drives state into saturation
				write_reg(sffe_pkg::REG_POLE_COS, 16'h8000);
				write_reg(sffe_pkg::REG_POLE_SIN, 16'h8000);
				mode = sffe_pkg::CFG_DATA_W'($urandom) & 16'hFFFE;
				write_reg(sffe_pkg::REG_DIFF, mode);
			end else begin
				write_reg(sffe_pkg::REG_POLE_COS, pick_coef());
				write_reg(sffe_pkg::REG_POLE_SIN, pick_coef());
				write_reg(sffe_pkg::REG_DIFF, sffe_pkg::CFG_DATA_W'($urandom));
				if ($urandom_range(0, 3) == 0)
					write_reg(REG_NONE, sffe_pkg::CFG_DATA_W'($urandom));
			end
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (k == 0)
					sos = $urandom_range(0, 1);
				else
					sos = ($urandom_range(0, (ph == 0) ? 200 : 15) == 0);
				send_sample(pick_sample(), sos, 1'b0, '0);
			end
		end
		in_valid <= 1'b0;
		in_up = 1'b0;
		while (expected_powers.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("single_frequency_filter_envelope_test: done, clean");
		else
			$display("single_frequency_filter_envelope_test: done, errors");
		$finish;
	end

	// Receiver: random stalls, one long hold-off, and the result check
	initial begin : drain
		int unsigned                gap;
		logic [sffe_pkg::ENV_W-1:0] want;
		wait (arst_n === 1'b1);
		forever begin
			gap = (taken == HOLD_AT_BEAT) ? HOLD_CYCLES : pause_for(taken);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (expected_powers.size() == 0) begin
				$display("%0t: unexpected beat, envelope_power %0d", $time, envelope_power);
				errors++;
			end else begin
				want = expected_powers.pop_front();
				if (envelope_power !== want) begin
					$display("%0t: envelope_power expected %0d, got %0d",
						$time, want, envelope_power);
					errors++;
				end
			end
			taken++;
		end
	end

	// Hard limit on the run
	initial begin
		#3_000_000;
		$display("single_frequency_filter_envelope_test: done, errors");
		$finish;
	end

endmodule
